[rtl/mse_pkg.sv]
// ----------------------------------------------------------------------------
// mse_pkg
// Shared widths, opcodes, status codes and the register write request type
// for the MIPS subset executor.
// ----------------------------------------------------------------------------
package mse_pkg;

	localparam int XLEN      = 32;
	localparam int NUM_REGS  = 32;
	localparam int REG_AW    = $clog2(NUM_REGS);
	localparam int CFG_IDX_W = 1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ROM_BASE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_JR_BIAS  = 1'b1;

	localparam logic [XLEN-1:0] JR_BIAS_RESET = 32'h0001_0000;

	// primary opcodes
	localparam logic [5:0] OP_SPECIAL = 6'h00;
	localparam logic [5:0] OP_JAL     = 6'h03;
	localparam logic [5:0] OP_BNE     = 6'h05;
	localparam logic [5:0] OP_ADDI    = 6'h08;
	localparam logic [5:0] OP_ADDIU   = 6'h09;
	localparam logic [5:0] OP_ORI     = 6'h0D;
	localparam logic [5:0] OP_LUI     = 6'h0F;
	localparam logic [5:0] OP_SW      = 6'h2B;

	// special function codes
	localparam logic [5:0] FN_JR = 6'h08;

	localparam logic [REG_AW-1:0] LINK_REG = REG_AW'(31);

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_HALTED   = 3'd1,
		ST_ILLEGAL  = 3'd2,
		ST_OVERFLOW = 3'd3,
		ST_ADDR_ERR = 3'd4
	} status_t;

	// write request into the register file
	typedef struct packed {
		logic              en;
		logic [REG_AW-1:0] addr;
		logic [XLEN-1:0]   data;
	} gpr_wr_t;

endpackage

[rtl/mse_channels.sv]
// ----------------------------------------------------------------------------
// mse channels
// Valid/ready channels for instruction requests and execution results.
// ----------------------------------------------------------------------------
interface mse_insn_if;
	logic        valid;
	logic        ready;
	logic [31:0] instruction;

	modport source (output valid, output instruction, input ready);
	modport sink (input valid, input instruction, output ready);
endinterface

interface mse_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] next_offset;
	logic [2:0]  status;
	logic        store_valid;
	logic [31:0] store_offset;
	logic [31:0] store_data;

	modport source (output valid, output next_offset, output status, output store_valid,
		output store_offset, output store_data, input ready);
	modport sink (input valid, input next_offset, input status, input store_valid,
		input store_offset, input store_data, output ready);
endinterface

[rtl/mips_subset_executor.sv]
// ----------------------------------------------------------------------------
// mips_subset_executor
// Executes a subset of MIPS32 instructions against a 32-entry register file
// and reports next fetch offset, status and word store requests.
//
//   channel   role     fields
//   insn      sink     instruction[31:0]
//   result    source   next_offset, status, store_valid, store_offset,
//                      store_data
//   cfg       write    cfg_we, cfg_addr (0 rom base, 1 jump bias), cfg_data
//
// One request per cycle while the result is not stalled; a request is
// registered in stage 1 with its register file read, then in the result register.
// A write back and a read of the same register on one edge are bypassed.
// A stalled result holds the execute stage; one request waits in stage 1.
// Reset clears register file valid bits, offset and halt flag, and returns
// rom base to zero and jump bias to its default.
// ----------------------------------------------------------------------------
module mips_subset_executor (
	input  logic                           clk,
	input  logic                           arst_n,
	mse_insn_if.sink                       insn,
	mse_result_if.source                   result,
	input  logic                           cfg_we,
	input  logic [mse_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  logic [mse_pkg::XLEN-1:0]       cfg_data
);
	import mse_pkg::*;

	logic [XLEN-1:0] rom_base_q;
	logic [XLEN-1:0] jr_bias_q;
	logic [XLEN-1:0] jr_total_q;
	logic            valid_s1;
	logic [31:0]     instruction_s1;
	logic [XLEN-1:0] imm_minus_base_s1;
	logic            accept;
	logic            fire;
	gpr_wr_t         wr;
	logic [XLEN-1:0] rs_data;
	logic [XLEN-1:0] rt_data;

	assign insn.ready = !valid_s1 || fire;
	assign accept     = insn.valid && insn.ready;

	// configuration registers and combined jump offset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_base_q <= '0;
			jr_bias_q  <= JR_BIAS_RESET;
			jr_total_q <= JR_BIAS_RESET;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					CFG_ROM_BASE: rom_base_q <= cfg_data;
					CFG_JR_BIAS:  jr_bias_q  <= cfg_data;
					default: ;
				endcase
			end
			jr_total_q <= rom_base_q + jr_bias_q;
		end
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage 1 payload and store offset precompute
	always_ff @(posedge clk) begin
		if (accept) begin
			instruction_s1    <= insn.instruction;
			imm_minus_base_s1 <= {{(XLEN-16){insn.instruction[15]}}, insn.instruction[15:0]}
				- rom_base_q;
		end
	end

	mse_regfile u_regfile (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (accept),
		.rd_addr_a (insn.instruction[25:21]),
		.rd_addr_b (insn.instruction[20:16]),
		.wr        (wr),
		.rd_data_a (rs_data),
		.rd_data_b (rt_data)
	);

	mse_exec u_exec (
		.clk               (clk),
		.arst_n            (arst_n),
		.valid_s1          (valid_s1),
		.instruction_s1    (instruction_s1),
		.imm_minus_base_s1 (imm_minus_base_s1),
		.rs_data           (rs_data),
		.rt_data           (rt_data),
		.rom_base          (rom_base_q),
		.jr_total          (jr_total_q),
		.fire              (fire),
		.wr                (wr),
		.result            (result)
	);

endmodule

[rtl/mse_regfile.sv]
// ----------------------------------------------------------------------------
// mse_regfile
// General register file: synchronous memory with two registered read ports,
// one write port, per-entry valid bits for the cleared reset state and
// write-to-read bypass when both hit the same entry on one edge.
// ----------------------------------------------------------------------------
module mse_regfile (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      rd_en,
	input  logic [mse_pkg::REG_AW-1:0] rd_addr_a,
	input  logic [mse_pkg::REG_AW-1:0] rd_addr_b,
	input  mse_pkg::gpr_wr_t          wr,
	output logic [mse_pkg::XLEN-1:0]  rd_data_a,
	output logic [mse_pkg::XLEN-1:0]  rd_data_b
);
	import mse_pkg::*;

	logic [XLEN-1:0]     mem [NUM_REGS];
	logic [NUM_REGS-1:0] valid_q;
	logic [XLEN-1:0]     raw_a_q;
	logic [XLEN-1:0]     raw_b_q;
	logic                zero_a_q;
	logic                zero_b_q;
	logic                hit_a;
	logic                hit_b;

	assign hit_a = wr.en && (wr.addr == rd_addr_a);
	assign hit_b = wr.en && (wr.addr == rd_addr_b);

	// memory array write and registered read with bypass
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			raw_a_q <= hit_a ? wr.data : mem[rd_addr_a];
			raw_b_q <= hit_b ? wr.data : mem[rd_addr_b];
		end
	end

	// valid bits and zero flags for never-written entries and register zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			zero_a_q <= 1'b1;
			zero_b_q <= 1'b1;
		end else begin
			if (wr.en) begin
				valid_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				zero_a_q <= (rd_addr_a == '0) || !(valid_q[rd_addr_a] || hit_a);
				zero_b_q <= (rd_addr_b == '0) || !(valid_q[rd_addr_b] || hit_b);
			end
		end
	end

	assign rd_data_a = zero_a_q ? '0 : raw_a_q;
	assign rd_data_b = zero_b_q ? '0 : raw_b_q;

endmodule

[rtl/mse_exec.sv]
// ----------------------------------------------------------------------------
// mse_exec
// Execute stage: decodes the instruction, computes next offset, status,
// register write back and store request, holds program offset and halt
// flag, and drives the result output register.
// ----------------------------------------------------------------------------
module mse_exec (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      valid_s1,
	input  logic [31:0]               instruction_s1,
	input  logic [mse_pkg::XLEN-1:0]  imm_minus_base_s1,
	input  logic [mse_pkg::XLEN-1:0]  rs_data,
	input  logic [mse_pkg::XLEN-1:0]  rt_data,
	input  logic [mse_pkg::XLEN-1:0]  rom_base,
	input  logic [mse_pkg::XLEN-1:0]  jr_total,
	output logic                      fire,
	output mse_pkg::gpr_wr_t          wr,
	mse_result_if.source              result
);
	import mse_pkg::*;

	logic [XLEN-1:0] pc_q;
	logic            halted_q;
	logic            out_valid_q;
	logic [XLEN-1:0] next_offset_q;
	status_t         status_q;
	logic            store_valid_q;
	logic [XLEN-1:0] store_offset_q;
	logic [XLEN-1:0] store_data_q;

	logic [5:0]        opcode;
	logic [REG_AW-1:0] rt;
	logic [15:0]       imm;
	logic [XLEN-1:0]   sext;
	logic [XLEN-1:0]   sum;
	logic [XLEN-1:0]   link;
	logic              halt;
	logic [XLEN-1:0]   next;
	status_t           status;
	logic              st_valid;
	logic [XLEN-1:0]   st_off;
	logic [XLEN-1:0]   st_data;
	logic              wr_en;
	logic [REG_AW-1:0] wr_addr;
	logic [XLEN-1:0]   wr_data;

	assign fire    = valid_s1 && (!out_valid_q || result.ready);
	assign opcode  = instruction_s1[31:26];
	assign rt      = instruction_s1[20:16];
	assign imm     = instruction_s1[15:0];
	assign sext    = {{(XLEN-16){imm[15]}}, imm};
	assign sum     = rs_data + sext;
	assign link    = pc_q + rom_base + XLEN'(4);
	assign halt    = halted_q || (instruction_s1 == '0);

	// instruction decode and execute
	always_comb begin
		next     = pc_q + XLEN'(4);
		status   = ST_OK;
		st_valid = 1'b0;
		st_off   = '0;
		st_data  = '0;
		wr_en    = 1'b0;
		wr_addr  = rt;
		wr_data  = '0;
		if (halt) begin
			next   = pc_q;
			status = ST_HALTED;
		end else begin
			unique case (opcode)
				OP_SPECIAL: begin
					if (instruction_s1[5:0] == FN_JR) begin
						next = rs_data - jr_total;
					end else begin
						status = ST_ILLEGAL;
					end
				end
				OP_JAL: begin
					wr_en   = 1'b1;
					wr_addr = LINK_REG;
					wr_data = link;
					next    = {link[31:28], instruction_s1[25:0], 2'b00} - rom_base;
				end
				OP_BNE: begin
					if (rs_data != rt_data) begin
						next = pc_q + XLEN'(4) + {sext[XLEN-3:0], 2'b00};
					end
				end
				OP_ADDI: begin
					if (!(rs_data[31] ^ sext[31]) && (rs_data[31] ^ sum[31])) begin
						status = ST_OVERFLOW;
					end else begin
						wr_en   = 1'b1;
						wr_data = sum;
					end
				end
				OP_ADDIU: begin
					wr_en   = 1'b1;
					wr_data = sum;
				end
				OP_ORI: begin
					wr_en   = 1'b1;
					wr_data = rs_data | {{(XLEN-16){1'b0}}, imm};
				end
				OP_LUI: begin
					wr_en   = 1'b1;
					wr_data = {imm, {(XLEN-16){1'b0}}};
				end
				OP_SW: begin
					if (sum[1:0] != 2'b00) begin
						status = ST_ADDR_ERR;
					end else begin
						st_valid = 1'b1;
						st_off   = rs_data + imm_minus_base_s1;
						st_data  = rt_data;
					end
				end
				default: begin
					status = ST_ILLEGAL;
				end
			endcase
		end
	end

	// write back request, register zero never written
	assign wr.en   = fire && wr_en && (wr_addr != '0);
	assign wr.addr = wr_addr;
	assign wr.data = wr_data;

	// architectural state and output control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= '0;
			halted_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				pc_q <= next;
				if (halt) begin
					halted_q <= 1'b1;
				end
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload register
	always_ff @(posedge clk) begin
		if (fire) begin
			next_offset_q  <= next;
			status_q       <= status;
			store_valid_q  <= st_valid;
			store_offset_q <= st_off;
			store_data_q   <= st_data;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.next_offset  = next_offset_q;
	assign result.status       = status_q;
	assign result.store_valid  = store_valid_q;
	assign result.store_offset = store_offset_q;
	assign result.store_data   = store_data_q;

	// once halted, no register write and the offset stays put
	a_halt_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |-> !wr.en)
		else $error("register write while halted");

	a_halt_pc_hold: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> $stable(pc_q))
		else $error("program offset moved while halted");

	a_pc_only_on_fire: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(pc_q) && $stable(halted_q))
		else $error("state changed without an executed request");

	a_store_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && store_valid_q |-> status_q == ST_OK)
		else $error("store reported with error status");

endmodule
